### rtl/core/tcw_pkg.sv
// Package for the text console writer: screen geometry, character codes,
// state encoding and the structs passed between the modules.
// Depends on nothing.
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = COLUMNS * ROWS;

  // Widths that follow from the geometry.
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int PTR_W      = $clog2(CELLS + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CNT_W      = $clog2(COLUMNS + 1);
  localparam int CELL_IDX_W = 11;
  localparam int CMP_W      = (PTR_W > CELL_IDX_W) ? PTR_W : CELL_IDX_W;
  localparam int CELL_W     = 16;

  // Input kinds.
  localparam logic [1:0] KIND_PUT  = 2'd0;
  localparam logic [1:0] KIND_INIT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BLANK     = 8'h00;
  localparam int         TAB_STOP     = 4;

  // Configuration port.
  localparam int         APB_AW      = 3;
  localparam logic [0:0] REG_ATTR    = 1'b0;
  localparam logic [7:0] ATTR_RESET  = 8'h02;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_mem_req_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] cursor_cell;
    logic [7:0]            read_char;
    logic [7:0]            read_attr;
  } tcw_result_t;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcw_regs.sv
// APB-style configuration register file holding the text attribute.
// Depends on tcw_pkg.
`default_nettype none

module tcw_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcw_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [7:0]                 attr_o
);

  import tcw_pkg::*;

  logic [7:0] attr_q, attr_d;
  logic       hit;

  // Registers are word aligned; the word index is the address above bit 1.
  assign hit    = (paddr[APB_AW-1:2] == REG_ATTR);
  assign pready = 1'b1;
  assign attr_o = attr_q;
  assign prdata = hit ? {24'h0, attr_q} : 32'h0;

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && hit) begin
      attr_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcw_engine.sv
// Sequencer of the text console: cursor state, character handling, scroll,
// clear and read, all through the write and read ports of the screen memory.
// Depends on tcw_pkg.
`default_nettype none

module tcw_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [7:0]                     char_code_i,
  input  wire logic [tcw_pkg::CELL_IDX_W-1:0] cell_index_i,
  input  wire logic [7:0]                     attr_i,
  output tcw_pkg::tcw_mem_req_t               mem_req_o,
  input  wire logic [tcw_pkg::CELL_W-1:0]     mem_rdata_i,
  output logic                                res_valid_o,
  output tcw_pkg::tcw_result_t                res_o,
  input  wire logic                           res_free_i
);

  import tcw_pkg::*;

  tcw_state_e        state_q, state_d;
  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              init_q, init_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [7:0]        ch_q, ch_d;
  logic [7:0]        rc_q, rc_d;
  logic [7:0]        ra_q, ra_d;

  logic accept;
  logic last_cell;
  logic last_row;
  logic idx_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_cell  = (cursor_q == ADDR_W'(CELLS - 1));
  assign last_row   = (row_q == ROW_W'(ROWS - 1));
  assign idx_ok     = (CMP_W'(cell_index_i) < CMP_W'(CELLS));

  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.cursor_cell = CELL_IDX_W'(cursor_q);
  assign res_o.read_char   = rc_q;
  assign res_o.read_attr   = ra_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WIPE: begin
        if (ptr_q == PTR_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_PUT: begin
              if (char_code_i == CH_NEWLINE && init_q) begin
                state_d = last_row ? ST_SCROLL : ST_DONE;
              end else if (char_code_i == CH_BACKSPACE) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_PUT;
              end
            end
            KIND_INIT: state_d = ST_FILL;
            KIND_READ: state_d = idx_ok ? ST_READ : ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        if (last_cell) begin
          state_d = ST_SCROLL;
        end else if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (ptr_q == PTR_W'(CELLS)) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (ptr_q == PTR_W'(CELLS - 1)) begin
          state_d = (cnt_q != '0) ? ST_PUT : ST_DONE;
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    cursor_d  = cursor_q;
    col_d     = col_q;
    row_d     = row_q;
    init_d    = init_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    ch_d      = ch_q;
    rc_d      = rc_q;
    ra_d      = ra_q;
    mem_req_o = '0;

    unique case (state_q)
      ST_WIPE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ADDR_W'(ptr_q);
        mem_req_o.wdata = '0;
        ptr_d           = ptr_q + PTR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          rc_d  = '0;
          ra_d  = '0;
          cnt_d = '0;
          unique case (kind_i)
            KIND_PUT: begin
              ch_d = CH_SPACE;
              if (char_code_i == CH_NEWLINE && init_q) begin
                if (last_row) begin
                  ptr_d    = PTR_W'(COLUMNS);
                  cursor_d = ADDR_W'((ROWS - 1) * COLUMNS);
                  row_d    = ROW_W'(ROWS - 1);
                  col_d    = '0;
                end else begin
                  cursor_d = cursor_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
                  row_d    = row_q + ROW_W'(1);
                  col_d    = '0;
                end
              end else if (char_code_i == CH_NEWLINE) begin
                cnt_d = CNT_W'(COLUMNS) - CNT_W'(col_q);
              end else if (char_code_i == CH_TAB) begin
                cnt_d = CNT_W'(TAB_STOP) - CNT_W'(col_q & COL_W'(TAB_STOP - 1));
              end else if (char_code_i == CH_BACKSPACE) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.wdata = {attr_i, CH_SPACE};
                if (cursor_q != '0) begin
                  cursor_d        = cursor_q - ADDR_W'(1);
                  mem_req_o.waddr = cursor_q - ADDR_W'(1);
                  if (col_q == '0) begin
                    col_d = COL_W'(COLUMNS - 1);
                    row_d = row_q - ROW_W'(1);
                  end else begin
                    col_d = col_q - COL_W'(1);
                  end
                end else begin
                  mem_req_o.waddr = '0;
                end
              end else begin
                cnt_d = CNT_W'(1);
                ch_d  = char_code_i;
              end
            end
            KIND_INIT: begin
              init_d = 1'b1;
              ptr_d  = PTR_W'(cursor_q - ADDR_W'(col_q));
            end
            KIND_READ: begin
              mem_req_o.re    = idx_ok;
              mem_req_o.raddr = ADDR_W'(cell_index_i);
            end
            default: begin
              rc_d = '0;
            end
          endcase
        end
      end
      ST_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cursor_q;
        mem_req_o.wdata = {attr_i, ch_q};
        cnt_d           = cnt_q - CNT_W'(1);
        if (last_cell) begin
          ptr_d    = PTR_W'(COLUMNS);
          cursor_d = ADDR_W'((ROWS - 1) * COLUMNS);
          row_d    = ROW_W'(ROWS - 1);
          col_d    = '0;
        end else begin
          cursor_d = cursor_q + ADDR_W'(1);
          if (col_q == COL_W'(COLUMNS - 1)) begin
            col_d = '0;
            row_d = row_q + ROW_W'(1);
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
      ST_SCROLL: begin
        // Read one row ahead, write the returned cell one row up in the next cycle.
        if (pend_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ADDR_W'(ptr_q - PTR_W'(COLUMNS + 1));
          mem_req_o.wdata = mem_rdata_i;
        end
        if (ptr_q != PTR_W'(CELLS)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ADDR_W'(ptr_q);
          ptr_d           = ptr_q + PTR_W'(1);
          pend_d          = 1'b1;
        end else begin
          ptr_d = PTR_W'((ROWS - 1) * COLUMNS);
        end
      end
      ST_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ADDR_W'(ptr_q);
        mem_req_o.wdata = {attr_i, CH_BLANK};
        ptr_d           = ptr_q + PTR_W'(1);
      end
      ST_READ: begin
        rc_d = mem_rdata_i[7:0];
        ra_d = mem_rdata_i[15:8];
      end
      ST_DONE: begin
        pend_d = 1'b0;
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_WIPE;
      cursor_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      init_q   <= 1'b0;
      cnt_q    <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      row_q    <= row_d;
      init_q   <= init_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    rc_q <= rc_d;
    ra_q <= ra_d;
  end

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// Top level of the text console writer: configuration registers, sequencer,
// screen memory and the result output register.
// Depends on tcw_pkg, tcw_regs, tcw_engine and tcw_ram.
`default_nettype none

//  Channel   Direction  Handshake              Word
//  input     in         in_valid_i/in_ready_o  kind_i, char_code_i, cell_index_i
//  result    out        out_valid_o/out_ready_i cursor_cell_o, read_char_o, read_attr_o
//  config    in         psel/penable/pwrite    paddr, pwdata, prdata (text attribute)
//
// One word is worked at a time; the screen memory's single write port sets
// the pace. A scroll moves one cell per cycle, then clears the bottom row.
// Init clears from the cursor row down, one cell per cycle. After reset the
// block clears the whole screen before it raises in_ready_o; configuration
// writes are taken meanwhile. A stalled result waits in the output register
// while the next word is accepted and worked; only its own result waits for
// the register.

module text_console_writer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input words.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [7:0]                     char_code_i,
  input  wire logic [tcw_pkg::CELL_IDX_W-1:0] cell_index_i,
  // Result words.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [tcw_pkg::CELL_IDX_W-1:0] cursor_cell_o,
  output logic      [7:0]                     read_char_o,
  output logic      [7:0]                     read_attr_o,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tcw_pkg::APB_AW-1:0]     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  import tcw_pkg::*;

  logic              [7:0] attr;
  tcw_mem_req_t            mem_req;
  logic       [CELL_W-1:0] mem_rdata;
  logic                    res_valid;
  tcw_result_t             res;
  logic                    res_free;

  logic        out_valid_q, out_valid_d;
  tcw_result_t out_q, out_d;

  tcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  tcw_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_free_i   (res_free)
  );

  // Screen memory: low byte is the character, high byte the attribute.
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result when empty or being drained.
  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_free) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_cell_o = out_q.cursor_cell;
  assign read_char_o   = out_q.read_char;
  assign read_attr_o   = out_q.read_attr;

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking bench for text_console_writer: drives console words, predicts every
// cursor report from its own model of the screen, and checks the results word by word.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  // No kind code is defined for the fourth encoding; the block must leave its state alone.
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [APB_AW-1:0] ATTR_ADDR = APB_AW'(4 * REG_ATTR);
  localparam int unsigned LAST_CELL = CELLS - 1;
  localparam int unsigned IDX_MAX = (1 << CELL_IDX_W) - 1;

  // One console word as queued for the driver. A word with hold set is not sent: the
  // driver stops there until every cursor report has come back, then drops it.
  typedef struct {
    bit                    hold;
    logic [1:0]            kind;
    logic [7:0]            char_code;
    logic [CELL_IDX_W-1:0] cell_index;
  } console_cmd_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            kind_i = KIND_PUT;
  logic [7:0]            char_code_i = 8'h00;
  logic [CELL_IDX_W-1:0] cell_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CELL_IDX_W-1:0] cursor_cell_o;
  logic [7:0]            read_char_o;
  logic [7:0]            read_attr_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  text_console_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .cell_index_i  (cell_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cursor_cell_o (cursor_cell_o),
    .read_char_o   (read_char_o),
    .read_attr_o   (read_attr_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Words waiting to be sent, and the cursor reports that accepted words still owe.
  console_cmd_t console_cmds[$];
  tcw_result_t  pending_reports[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatches = 0;

  // ---------------------------------------------------------------------------
  // Screen model. Each cell holds the attribute in the high byte and the
  // character in the low byte, exactly as the block stores it.
  // ---------------------------------------------------------------------------
  logic [15:0] screen_model [CELLS];
  int unsigned cursor_model = 0;
  bit          console_inited = 1'b0;
  logic [7:0]  attr_model = ATTR_RESET;

  initial begin
    foreach (screen_model[i]) screen_model[i] = '0;
  end

  // Once the cursor runs off the last cell, every row moves up one and the bottom
  // row is blanked with the current attribute.
  function automatic void scroll_if_past_end();
    if (cursor_model >= CELLS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {attr_model, CH_BLANK};
      cursor_model = CELLS - COLUMNS;
    end
  endfunction

  function automatic void put_cell(logic [7:0] ch);
    if (cursor_model < CELLS) screen_model[cursor_model] = {attr_model, ch};
    cursor_model++;
    scroll_if_past_end();
  endfunction

  // Applies one accepted word to the screen model and returns the report the block owes.
  function automatic tcw_result_t console_step(logic [1:0] kind, logic [7:0] ch,
                                               logic [CELL_IDX_W-1:0] idx);
    tcw_result_t report;
    int unsigned col;
    report = '0;
    col = cursor_model % COLUMNS;
    case (kind)
      KIND_PUT: begin
        if (ch == CH_NEWLINE) begin
          // Before init a newline is printed as spaces to the end of the row.
          if (!console_inited) begin
            repeat (COLUMNS - col) put_cell(CH_SPACE);
          end else begin
            cursor_model = (cursor_model / COLUMNS + 1) * COLUMNS;
            scroll_if_past_end();
          end
        end else if (ch == CH_TAB) begin
          repeat (TAB_STOP - (col % TAB_STOP)) put_cell(CH_SPACE);
        end else if (ch == CH_BACKSPACE) begin
          // At the top left cell the cell is blanked but the cursor stays put.
          if (cursor_model > 0) cursor_model--;
          screen_model[cursor_model] = {attr_model, CH_SPACE};
        end else begin
          put_cell(ch);
        end
      end
      KIND_INIT: begin
        for (int i = (cursor_model / COLUMNS) * COLUMNS; i < CELLS; i++) begin
          screen_model[i] = {attr_model, CH_BLANK};
        end
        console_inited = 1'b1;
      end
      KIND_READ: begin
        if (idx < CELLS) begin
          report.read_char = screen_model[idx][7:0];
          report.read_attr = screen_model[idx][15:8];
        end
      end
      default: ;
    endcase
    report.cursor_cell = CELL_IDX_W'(cursor_model);
    return report;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A new word is presented only when the channel is free after this
  // edge, so valid is never dropped under a pending word. The prediction is
  // made at the accepting edge from the payload that was on the pins.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_reports.push_back(console_step(kind_i, char_code_i, cell_index_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (console_cmds.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (console_cmds[0].hold) begin
          in_valid_i <= 1'b0;
          if (!in_valid_i && pending_reports.size() == 0) void'(console_cmds.pop_front());
        end else if ($urandom_range(99) < send_idle_pct) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i   <= 1'b1;
          kind_i       <= console_cmds[0].kind;
          char_code_i  <= console_cmds[0].char_code;
          cell_index_i <= console_cmds[0].cell_index;
          void'(console_cmds.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every accepted result word is matched against the oldest report
  // still owed. Printing is capped so a badly broken block cannot flood the log.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40) $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 40) begin
            $display("%0t: unexpected result, expected none, actual cursor %0d char %0d attr %0d",
                     $time, cursor_cell_o, read_char_o, read_attr_o);
          end
        end else begin
          check_field("cursor_cell", pending_reports[0].cursor_cell, cursor_cell_o);
          check_field("read_char", pending_reports[0].read_char, read_char_o);
          check_field("read_attr", pending_reports[0].read_attr, read_attr_o);
          void'(pending_reports.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(logic [1:0] kind, logic [7:0] ch, int unsigned idx);
    console_cmd_t cmd;
    cmd.hold = 1'b0;
    cmd.kind = kind;
    cmd.char_code = ch;
    cmd.cell_index = CELL_IDX_W'(idx);
    console_cmds.push_back(cmd);
  endtask

  // Random words: put_pct percent are printed bytes, with the control codes
  // weighted up. Reads mostly land on the screen, a few past its end, up to IDX_MAX.
  task automatic queue_random(int count, int put_pct, bit allow_init);
    int roll;
    int unsigned idx;
    logic [7:0] ch;
    repeat (count) begin
      ch = 8'($urandom_range(255));
      idx = ($urandom_range(99) < 4) ? $urandom_range(IDX_MAX, CELLS) : $urandom_range(LAST_CELL);
      roll = $urandom_range(99);
      if (roll < put_pct) begin
        roll = $urandom_range(99);
        if (roll < 10) ch = CH_NEWLINE;
        else if (roll < 18) ch = CH_TAB;
        else if (roll < 30) ch = CH_BACKSPACE;
        queue_cmd(KIND_PUT, ch, idx);
      end else if (allow_init && roll >= 97) begin
        queue_cmd(KIND_INIT, ch, idx);
      end else begin
        queue_cmd(KIND_READ, ch, idx);
      end
    end
  endtask

  // Returns once every queued word has been sent and answered.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (console_cmds.size() != 0 || in_valid_i || pending_reports.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_attribute(logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    attr_model = value;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    console_cmd_t hold_cmd;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words before init, with the reset attribute. Covers reads of the
    // blank screen at both ends and past the end, the unused kind, backspace at
    // the top left cell, tabs from mid-stop and from a stop, and newline padding.
    queue_cmd(KIND_READ, 8'h00, 0);
    queue_cmd(KIND_READ, 8'hFF, LAST_CELL);
    queue_cmd(KIND_READ, 8'h00, CELLS);
    queue_cmd(KIND_READ, 8'h00, IDX_MAX);
    queue_cmd(KIND_NONE, 8'hFF, IDX_MAX);
    queue_cmd(KIND_PUT, CH_BACKSPACE, 0);
    queue_cmd(KIND_PUT, 8'h41, 0);
    queue_cmd(KIND_PUT, 8'h00, 0);
    queue_cmd(KIND_PUT, 8'hFF, 0);
    queue_cmd(KIND_PUT, CH_TAB, 0);
    queue_cmd(KIND_PUT, CH_TAB, 0);
    queue_cmd(KIND_PUT, CH_BACKSPACE, 0);
    queue_cmd(KIND_PUT, CH_NEWLINE, 0);
    queue_cmd(KIND_PUT, CH_TAB, 0);
    queue_cmd(KIND_READ, 8'h00, 2);
    queue_cmd(KIND_READ, 8'h00, 7);
    queue_cmd(KIND_READ, 8'h00, COLUMNS - 1);
    wait_drained();

    // Random words before init with no idling. Printed bytes dominate so the
    // cursor runs past the bottom and the screen scrolls without init.
    write_attribute(8'hFF);
    queue_random(600, 75, 1'b0);
    wait_drained();

    // Init, a repeated init and newline after init, then random words with the
    // sender idling.
    write_attribute(8'h00);
    send_idle_pct = 65;
    queue_cmd(KIND_INIT, 8'h00, 0);
    queue_cmd(KIND_READ, 8'h00, CELLS - COLUMNS);
    queue_cmd(KIND_PUT, CH_NEWLINE, 0);
    queue_cmd(KIND_PUT, 8'h55, 0);
    queue_cmd(KIND_PUT, CH_BACKSPACE, 0);
    queue_cmd(KIND_INIT, 8'hFF, IDX_MAX);
    queue_cmd(KIND_PUT, CH_NEWLINE, 0);
    queue_cmd(KIND_READ, 8'h00, LAST_CELL);
    queue_random(420, 60, 1'b1);
    wait_drained();

    // Receiver stalling; halfway through, the sender waits for every report.
    write_attribute(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_stall_pct = 65;
    queue_random(200, 60, 1'b1);
    hold_cmd.hold = 1'b1;
    hold_cmd.kind = KIND_PUT;
    hold_cmd.char_code = 8'h00;
    hold_cmd.cell_index = '0;
    console_cmds.push_back(hold_cmd);
    queue_random(220, 60, 1'b1);
    wait_drained();

    // Both sides idling.
    write_attribute(8'($urandom_range(255)));
    send_idle_pct = 30;
    recv_stall_pct = 30;
    queue_random(420, 60, 1'b1);
    wait_drained();

    // Give a stray late result time to show up: a scroll is the longest job.
    repeat (CELLS + 100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Safety net for a hung handshake, sized for every word scrolling under full stalls.
  initial begin
    #80_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
